// ----- design/utf8v_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package utf8v_pkg;

  // Range allowed for the next continuation byte.
  typedef enum logic [2:0] {
    CLS_PLAIN = 3'd0,  // 80..BF
    CLS_AFTER_E0 = 3'd1,  // A0..BF
    CLS_AFTER_ED = 3'd2,  // 80..9F
    CLS_AFTER_F0 = 3'd3,  // 90..BF
    CLS_AFTER_F4 = 3'd4   // 80..8F
  } cls_t;

  typedef struct packed {
    logic [1:0] pending;
    cls_t       cls;
    logic       err;
  } utf8v_state_t;

  localparam utf8v_state_t STATE_RESET = '{pending: 2'd0, cls: CLS_PLAIN, err: 1'b0};

  localparam logic [7:0] BYTE_CONT_LO = 8'h80;
  localparam logic [7:0] BYTE_CONT_90 = 8'h90;
  localparam logic [7:0] BYTE_CONT_A0 = 8'ha0;
  localparam logic [7:0] BYTE_CONT_HI = 8'hbf;
  localparam logic [7:0] BYTE_TWO_LO = 8'hc2;
  localparam logic [7:0] BYTE_TWO_HI = 8'hdf;
  localparam logic [7:0] BYTE_THREE_LO = 8'he0;
  localparam logic [7:0] BYTE_SURR_LEAD = 8'hed;
  localparam logic [7:0] BYTE_THREE_HI = 8'hef;
  localparam logic [7:0] BYTE_FOUR_LO = 8'hf0;
  localparam logic [7:0] BYTE_FOUR_HI = 8'hf4;
  localparam logic [1:0] CONT_MASK = 2'b10;

endpackage

`default_nettype wire

// ----- design/utf8v_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module utf8v_step (
  input  wire utf8v_pkg::utf8v_state_t state,
  input  wire logic [7:0]              text_byte,
  output utf8v_pkg::utf8v_state_t      state_next,
  output logic                         msg_ok
);

  logic cont_ok;

  always_comb begin
    case (state.cls)
      utf8v_pkg::CLS_AFTER_E0:
        cont_ok = (text_byte >= utf8v_pkg::BYTE_CONT_A0) &&
                  (text_byte <= utf8v_pkg::BYTE_CONT_HI);
      utf8v_pkg::CLS_AFTER_ED:
        cont_ok = (text_byte >= utf8v_pkg::BYTE_CONT_LO) &&
                  (text_byte < utf8v_pkg::BYTE_CONT_A0);
      utf8v_pkg::CLS_AFTER_F0:
        cont_ok = (text_byte >= utf8v_pkg::BYTE_CONT_90) &&
                  (text_byte <= utf8v_pkg::BYTE_CONT_HI);
      utf8v_pkg::CLS_AFTER_F4:
        cont_ok = (text_byte >= utf8v_pkg::BYTE_CONT_LO) &&
                  (text_byte < utf8v_pkg::BYTE_CONT_90);
      default:
        cont_ok = (text_byte[7:6] == utf8v_pkg::CONT_MASK);
    endcase
  end

  always_comb begin
    state_next     = state;
    state_next.cls = utf8v_pkg::CLS_PLAIN;
    if (state.pending != 2'd0) begin
      if (!cont_ok) begin
        state_next.err = 1'b1;
      end
      state_next.pending = state.pending - 2'd1;
    end else if (text_byte == 8'd0) begin
      state_next.err = 1'b1;
    end else if (text_byte < utf8v_pkg::BYTE_CONT_LO) begin
      state_next.pending = 2'd0;
    end else if ((text_byte >= utf8v_pkg::BYTE_TWO_LO) &&
                 (text_byte <= utf8v_pkg::BYTE_TWO_HI)) begin
      state_next.pending = 2'd1;
    end else if ((text_byte >= utf8v_pkg::BYTE_THREE_LO) &&
                 (text_byte <= utf8v_pkg::BYTE_THREE_HI)) begin
      state_next.pending = 2'd2;
      if (text_byte == utf8v_pkg::BYTE_THREE_LO) begin
        state_next.cls = utf8v_pkg::CLS_AFTER_E0;
      end else if (text_byte == utf8v_pkg::BYTE_SURR_LEAD) begin
        state_next.cls = utf8v_pkg::CLS_AFTER_ED;
      end
    end else if ((text_byte >= utf8v_pkg::BYTE_FOUR_LO) &&
                 (text_byte <= utf8v_pkg::BYTE_FOUR_HI)) begin
      state_next.pending = 2'd3;
      if (text_byte == utf8v_pkg::BYTE_FOUR_LO) begin
        state_next.cls = utf8v_pkg::CLS_AFTER_F0;
      end else if (text_byte == utf8v_pkg::BYTE_FOUR_HI) begin
        state_next.cls = utf8v_pkg::CLS_AFTER_F4;
      end
    end else begin
      state_next.err = 1'b1;
    end
  end

  // A truncated sequence at the end of the message counts as an error.
  assign msg_ok = !state_next.err && (state_next.pending == 2'd0);

endmodule

`default_nettype wire

// ----- design/utf8v_result.sv -----
`timescale 1ns / 1ps
`default_nettype none

module utf8v_result (
  input  wire  clk,
  input  wire  rst,
  input  wire  load,
  input  wire  load_value,
  input  wire  out_ready,
  output logic slot_free,
  output logic out_valid,
  output logic text_valid
);

  logic out_valid_next;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      text_valid <= load_value;
    end
  end

endmodule

`default_nettype wire

// ----- design/utf8_stream_validator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Strict UTF-8 checker for a byte stream.
// Input channel: in_valid / in_ready carry one byte of text (text_byte) per
// transaction, with last_byte high on the final byte of a message.
// Output channel: out_valid / out_ready carry one transaction per message,
// text_valid, which is 1 when the whole message was well formed UTF-8 with
// no overlong forms, surrogates, code points above U+10FFFF, illegal lead
// bytes, stray continuation bytes or zero bytes.
// The registered result is valid in the cycle after the final byte is taken.
// Throughput: one byte per cycle while the output slot is free; the decode
// state is updated by a single level of byte-range compares between the
// state and result registers, so bytes and messages can follow back to back.
// When the receiver stalls, the result stays in the output register and
// in_ready drops until it is taken; no byte is taken while the output slot
// is full.
// Reset clears the decode state and empties the output register; after each
// final byte the decode state returns to its reset value.
module utf8_stream_validator_unit (
  input  wire       clk,
  input  wire       rst,
  input  wire       in_valid,
  output logic      in_ready,
  input  wire [7:0] text_byte,
  input  wire       last_byte,
  output logic      out_valid,
  input  wire       out_ready,
  output logic      text_valid
);

  utf8v_pkg::utf8v_state_t state;
  utf8v_pkg::utf8v_state_t state_step;
  utf8v_pkg::utf8v_state_t state_next;
  logic                    msg_ok;
  logic                    slot_free;
  logic                    accept;

  assign in_ready = slot_free;
  assign accept   = in_valid && in_ready;

  utf8v_step u_step (
    .state      (state),
    .text_byte  (text_byte),
    .state_next (state_step),
    .msg_ok     (msg_ok)
  );

  always_comb begin
    state_next = state;
    if (accept) begin
      state_next = last_byte ? utf8v_pkg::STATE_RESET : state_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= utf8v_pkg::STATE_RESET;
    end else begin
      state <= state_next;
    end
  end

  utf8v_result u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && last_byte),
    .load_value (msg_ok),
    .out_ready  (out_ready),
    .slot_free  (slot_free),
    .out_valid  (out_valid),
    .text_valid (text_valid)
  );

endmodule

`default_nettype wire

// ----- design/utf8v_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module utf8v_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_ready,
  input wire [7:0] text_byte,
  input wire       last_byte,
  input wire       out_valid,
  input wire       out_ready,
  input wire       text_valid
);

  // A stalled result must hold its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(text_valid))
    else $error("result changed while stalled");

  // The final byte of a message produces a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_byte |=> out_valid)
    else $error("missing result after final byte");

  // A zero byte anywhere makes the message invalid; this check covers a zero final byte.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_byte && (text_byte == 8'd0) |=> !text_valid)
    else $error("zero final byte reported valid");

  // No byte is taken while a result waits to be taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output slot is full");

  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind utf8_stream_validator_unit utf8v_checker u_utf8v_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .text_byte  (text_byte),
  .last_byte  (last_byte),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .text_valid (text_valid)
);

`default_nettype wire
